// ===== rtl/sbtt_pkg.sv =====
package sbtt_pkg;

  localparam int unsigned TableDepthDef = 8;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned TimeW = 32;
  localparam int unsigned AttW  = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_RECORD = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic              track;
    logic [TimeW-1:0]  new_time;
    logic [IdxW-1:0]   slot_index;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [IdxW-1:0]   slot_used;
    logic [TimeW-1:0]  entry_time;
    logic [AttW-1:0]   entry_attempt;
    logic [AttW-1:0]   attempt_total;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

// ===== rtl/sbtt_req_if.sv =====
interface sbtt_req_if;
  logic                        valid;
  logic                        ready;
  logic [sbtt_pkg::CmdW-1:0]   command;
  logic                        track;
  logic [sbtt_pkg::TimeW-1:0]  new_time;
  logic [sbtt_pkg::IdxW-1:0]   slot_index;

  modport source (output valid, command, track, new_time, slot_index, input ready);
  modport sink   (input valid, command, track, new_time, slot_index, output ready);
endinterface

// ===== rtl/sbtt_rsp_if.sv =====
interface sbtt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [sbtt_pkg::IdxW-1:0]   slot_used;
  logic [sbtt_pkg::TimeW-1:0]  entry_time;
  logic [sbtt_pkg::AttW-1:0]   entry_attempt;
  logic [sbtt_pkg::AttW-1:0]   attempt_total;

  modport source (output valid, ok, slot_used, entry_time, entry_attempt, attempt_total,
                  input ready);
  modport sink   (input valid, ok, slot_used, entry_time, entry_attempt, attempt_total,
                  output ready);
endinterface

// ===== rtl/sbtt_mem.sv =====
module sbtt_mem #(
  parameter int unsigned Entries = 2 * sbtt_pkg::TableDepthDef,
  parameter int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [sbtt_pkg::TimeW-1:0] wr_time_i,
  input  logic [sbtt_pkg::AttW-1:0]  wr_att_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [sbtt_pkg::TimeW-1:0] rd_time_o,
  output logic [sbtt_pkg::AttW-1:0]  rd_att_o
);

  logic [sbtt_pkg::TimeW-1:0] time_mem [Entries];
  logic [sbtt_pkg::AttW-1:0]  att_mem  [Entries];
  logic [Entries-1:0]         vld_q;
  logic                       rd_vld_q;
  logic [sbtt_pkg::TimeW-1:0] rd_time_q;
  logic [sbtt_pkg::AttW-1:0]  rd_att_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i] <= wr_time_i;
      att_mem[wr_addr_i]  <= wr_att_i;
    end
    if (rd_en_i) begin
      rd_time_q <= time_mem[rd_addr_i];
      rd_att_q  <= att_mem[rd_addr_i];
    end
  end

  // entries never written since reset read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_time_o = rd_vld_q ? rd_time_q : '0;
  assign rd_att_o  = rd_vld_q ? rd_att_q  : '0;

endmodule

// ===== rtl/sbtt_seq.sv =====
module sbtt_seq #(
  parameter int unsigned TableDepth = sbtt_pkg::TableDepthDef,
  parameter int unsigned AddrW      = $clog2(2 * TableDepth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  sbtt_pkg::req_t             req_i,
  input  logic                       ack_i,
  output sbtt_pkg::seq_stat_t        stat_o,
  output sbtt_pkg::rsp_t             rsp_o,
  output logic                       wr_en_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output logic [sbtt_pkg::TimeW-1:0] wr_time_o,
  output logic [sbtt_pkg::AttW-1:0]  wr_att_o,
  output logic                       rd_en_o,
  output logic [AddrW-1:0]           rd_addr_o,
  input  logic [sbtt_pkg::TimeW-1:0] rd_time_i,
  input  logic [sbtt_pkg::AttW-1:0]  rd_att_i
);

  localparam int unsigned IdxW  = sbtt_pkg::IdxW;
  localparam int unsigned IdxWp = IdxW + 1;
  localparam int unsigned AddrWp = AddrW + 1;
  localparam logic [IdxW-1:0]   LastIdx = IdxW'(TableDepth - 1);
  localparam logic [IdxWp-1:0]  DepthC  = IdxWp'(TableDepth);
  localparam logic [AddrWp-1:0] EntriesC = AddrWp'(2 * TableDepth);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_RM_HEAD,
    ST_RM_WALK,
    ST_RM_TAIL,
    ST_RD,
    ST_DONE
  } state_e;

  state_e                     state_q;
  logic                       trk_q;
  logic [sbtt_pkg::TimeW-1:0] time_q;
  logic [IdxW-1:0]            idx_q;
  logic                       ins_q;
  logic [sbtt_pkg::TimeW-1:0] carry_time_q;
  logic [sbtt_pkg::AttW-1:0]  carry_att_q;
  logic [sbtt_pkg::AttW-1:0]  att_new_q;
  logic [sbtt_pkg::AttW-1:0]  cnt_q [2];
  logic                       ok_q;
  logic [IdxW-1:0]            slot_q;
  logic [sbtt_pkg::TimeW-1:0] etime_q;
  logic [sbtt_pkg::AttW-1:0]  eatt_q;

  logic            hit;
  logic            last;
  logic            empty;
  logic            in_range;
  logic [IdxW-1:0] nxt;

  function automatic logic [AddrW-1:0] slot_addr(input logic trk, input logic [IdxW-1:0] i);
    return trk ? (AddrW'(TableDepth) + AddrW'(i)) : AddrW'(i);
  endfunction

  // shared compare: insert before an empty entry or a strictly larger time
  assign empty    = (rd_time_i == '0);
  assign hit      = empty || (time_q < rd_time_i);
  assign last     = (idx_q == LastIdx);
  assign nxt      = idx_q + IdxW'(1);
  assign in_range = ({1'b0, req_i.slot_index} < DepthC);

  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = slot_addr(trk_q, idx_q);
    wr_time_o = carry_time_q;
    wr_att_o  = carry_att_q;
    rd_en_o   = 1'b0;
    rd_addr_o = slot_addr(trk_q, nxt);
    case (state_q)
      ST_IDLE: begin
        rd_addr_o = slot_addr(req_i.track,
                              (req_i.command == sbtt_pkg::CMD_RECORD) ? '0 : req_i.slot_index);
        case (req_i.command)
          sbtt_pkg::CMD_RECORD: rd_en_o = start_i && (req_i.new_time != '0);
          sbtt_pkg::CMD_REMOVE,
          sbtt_pkg::CMD_READ:   rd_en_o = start_i && in_range;
          default:              rd_en_o = 1'b0;
        endcase
      end
      ST_REC: begin
        if (!ins_q) begin
          wr_en_o   = hit;
          wr_time_o = time_q;
          wr_att_o  = att_new_q;
        end else begin
          wr_en_o = 1'b1;
        end
        rd_en_o = !last;
      end
      ST_RM_HEAD: begin
        rd_en_o = !empty && !last;
      end
      ST_RM_WALK: begin
        wr_en_o   = 1'b1;
        wr_addr_o = slot_addr(trk_q, idx_q - IdxW'(1));
        wr_time_o = rd_time_i;
        wr_att_o  = rd_att_i;
        rd_en_o   = !last;
      end
      ST_RM_TAIL: begin
        wr_en_o   = 1'b1;
        wr_time_o = '0;
        wr_att_o  = '0;
      end
      default: begin
        wr_en_o = 1'b0;
        rd_en_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      trk_q        <= 1'b0;
      time_q       <= '0;
      idx_q        <= '0;
      ins_q        <= 1'b0;
      carry_time_q <= '0;
      carry_att_q  <= '0;
      att_new_q    <= '0;
      cnt_q[0]     <= '0;
      cnt_q[1]     <= '0;
      ok_q         <= 1'b0;
      slot_q       <= '0;
      etime_q      <= '0;
      eatt_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            trk_q     <= req_i.track;
            time_q    <= req_i.new_time;
            ins_q     <= 1'b0;
            ok_q      <= 1'b0;
            etime_q   <= '0;
            eatt_q    <= '0;
            att_new_q <= cnt_q[req_i.track] + sbtt_pkg::AttW'(1);
            case (req_i.command)
              sbtt_pkg::CMD_RECORD: begin
                idx_q   <= '0;
                slot_q  <= '0;
                state_q <= (req_i.new_time != '0) ? ST_REC : ST_DONE;
              end
              sbtt_pkg::CMD_REMOVE: begin
                idx_q   <= req_i.slot_index;
                slot_q  <= req_i.slot_index;
                state_q <= in_range ? ST_RM_HEAD : ST_DONE;
              end
              sbtt_pkg::CMD_READ: begin
                idx_q   <= req_i.slot_index;
                slot_q  <= req_i.slot_index;
                state_q <= in_range ? ST_RD : ST_DONE;
              end
              default: begin
                idx_q   <= '0;
                slot_q  <= '0;
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_REC: begin
          // once inserted, every later entry moves down one place
          carry_time_q <= rd_time_i;
          carry_att_q  <= rd_att_i;
          if (!ins_q && hit) begin
            ins_q   <= 1'b1;
            ok_q    <= 1'b1;
            slot_q  <= idx_q;
            etime_q <= time_q;
            eatt_q  <= att_new_q;
          end
          if (last) begin
            if (ins_q || hit) begin
              cnt_q[trk_q] <= att_new_q;
            end
            state_q <= ST_DONE;
          end else begin
            idx_q <= nxt;
          end
        end
        ST_RM_HEAD: begin
          if (empty) begin
            state_q <= ST_DONE;
          end else begin
            ok_q    <= 1'b1;
            etime_q <= rd_time_i;
            eatt_q  <= rd_att_i;
            if (last) begin
              state_q <= ST_RM_TAIL;
            end else begin
              idx_q   <= nxt;
              state_q <= ST_RM_WALK;
            end
          end
        end
        ST_RM_WALK: begin
          if (last) begin
            state_q <= ST_RM_TAIL;
          end else begin
            idx_q <= nxt;
          end
        end
        ST_RM_TAIL: begin
          state_q <= ST_DONE;
        end
        ST_RD: begin
          if (!empty) begin
            ok_q    <= 1'b1;
            etime_q <= rd_time_i;
            eatt_q  <= rd_att_i;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (ack_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);

  assign rsp_o.ok            = ok_q;
  assign rsp_o.slot_used     = slot_q;
  assign rsp_o.entry_time    = etime_q;
  assign rsp_o.entry_attempt = eatt_q;
  assign rsp_o.attempt_total = cnt_q[trk_q];

  a_wr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> ({1'b0, wr_addr_o} < EntriesC))
    else $error("table write outside track storage");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!wr_en_o && !rd_en_o))
    else $error("table access while result pending");

  a_ack_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.done && ack_i) |=> stat_o.idle)
    else $error("sequencer did not return to idle after result taken");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REC && last && (ins_q || hit))
      |=> (cnt_q[trk_q] == $past(cnt_q[trk_q]) + sbtt_pkg::AttW'(1)))
    else $error("attempt counter not stepped on successful record");

endmodule

// ===== rtl/sorted_best_time_table_top.sv =====
// Record: one compare-and-shift pass per entry from accept to result.
// Remove: at most a shift-up pass plus clearing the last entry.
// Read: one table lookup; rejected commands go straight to the result. One item at a time;
// the next item is accepted once the sequencer has handed its result to the output register.
// Reset (asynchronous, active low) empties both tables and clears both attempt counters.
module sorted_best_time_table_top #(
  parameter int unsigned TableDepth = sbtt_pkg::TableDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sbtt_req_if.sink     req_i,
  sbtt_rsp_if.source   rsp_o
);

  localparam int unsigned Entries = 2 * TableDepth;
  localparam int unsigned AddrW   = $clog2(Entries);

  sbtt_pkg::req_t      req;
  sbtt_pkg::rsp_t      seq_rsp;
  sbtt_pkg::seq_stat_t stat;
  sbtt_pkg::rsp_t      out_q;
  logic                out_vld_q;
  logic                start;
  logic                ack;

  logic                       wr_en;
  logic [AddrW-1:0]           wr_addr;
  logic [sbtt_pkg::TimeW-1:0] wr_time;
  logic [sbtt_pkg::AttW-1:0]  wr_att;
  logic                       rd_en;
  logic [AddrW-1:0]           rd_addr;
  logic [sbtt_pkg::TimeW-1:0] rd_time;
  logic [sbtt_pkg::AttW-1:0]  rd_att;

  assign req.command    = sbtt_pkg::cmd_e'(req_i.command);
  assign req.track      = req_i.track;
  assign req.new_time   = req_i.new_time;
  assign req.slot_index = req_i.slot_index;

  assign req_i.ready = stat.idle;
  assign start       = req_i.valid && stat.idle;
  // result moves on when the output register is free or being emptied
  assign ack         = stat.done && (!out_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ack) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_q <= seq_rsp;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.ok            = out_q.ok;
  assign rsp_o.slot_used     = out_q.slot_used;
  assign rsp_o.entry_time    = out_q.entry_time;
  assign rsp_o.entry_attempt = out_q.entry_attempt;
  assign rsp_o.attempt_total = out_q.attempt_total;

  sbtt_seq #(
    .TableDepth (TableDepth),
    .AddrW      (AddrW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req),
    .ack_i     (ack),
    .stat_o    (stat),
    .rsp_o     (seq_rsp),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_time_o (wr_time),
    .wr_att_o  (wr_att),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_time_i (rd_time),
    .rd_att_i  (rd_att)
  );

  sbtt_mem #(
    .Entries (Entries),
    .AddrW   (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_time_i (wr_time),
    .wr_att_i  (wr_att),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_time_o (rd_time),
    .rd_att_o  (rd_att)
  );

endmodule
